// ===== src/csmm_pkg.sv =====
// Shared types, codes and arithmetic helpers for the CSR sparse-dense matrix multiplier.
package csmm_pkg;

    localparam int DEF_MAX_ROWS     = 8;
    localparam int DEF_MAX_COLS     = 8;
    localparam int DEF_MAX_INNER    = 8;
    localparam int DEF_MAX_NONZEROS = 64;

    localparam int VAL_W  = 32;
    localparam int PTR_W  = 7;
    localparam int SIZE_W = 4;
    localparam int KC_W   = 4;
    // accumulator holds up to 126 rounded products of magnitude 2^46
    localparam int ACC_W  = 54;
    // scaled sum: capped alpha term (2^60) plus beta term (2^46)
    localparam int TOT_W  = 62;

    localparam logic [63:0] MAG_CAP    = 64'h1 << 60;
    localparam logic [63:0] HI_LIMIT   = 64'h1 << 44;
    localparam logic [63:0] ROUND_HALF = 64'h8000;

    // input item kinds
    localparam logic [2:0] KIND_ROW_PTR = 3'd0;
    localparam logic [2:0] KIND_NONZERO = 3'd1;
    localparam logic [2:0] KIND_B_ELEM  = 3'd2;
    localparam logic [2:0] KIND_C_ELEM  = 3'd3;
    localparam logic [2:0] KIND_START   = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_ROWS  = 3'd0;
    localparam logic [2:0] CFG_COLS  = 3'd1;
    localparam logic [2:0] CFG_INNER = 3'd2;
    localparam logic [2:0] CFG_ALPHA = 3'd3;
    localparam logic [2:0] CFG_BETA  = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROW_LO,
        ST_ROW_HI,
        ST_ROW_WAIT,
        ST_NZ_CHECK,
        ST_NZ_READ,
        ST_B_READ,
        ST_MUL_WAIT,
        ST_ALPHA_LO,
        ST_ALPHA_HI,
        ST_BETA,
        ST_SUM,
        ST_TOTAL,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [SIZE_W-1:0] rows;
        logic [SIZE_W-1:0] cols;
        logic [SIZE_W-1:0] inner;
        logic [VAL_W-1:0]  alpha;
        logic [VAL_W-1:0]  beta;
    } cfg_t;

    typedef struct packed {
        logic [2:0]       kind;
        logic [5:0]       slot;
        logic [PTR_W-1:0] pointer;
        logic [3:0]       column;
        logic [2:0]       row;
        logic [2:0]       col;
        logic [VAL_W-1:0] value;
    } item_t;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [2:0]       row;
        logic [2:0]       col;
        logic             saturated;
        logic             last;
    } result_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
    } mul_req_t;

    // magnitude of a two's complement word; -2^31 maps to 2^31
    function automatic logic [31:0] mag32(input logic [31:0] x);
        return x[31] ? (~x + 32'd1) : x;
    endfunction

    // round a Q.32 magnitude to Q.16, half away from zero
    function automatic logic [63:0] rnd16(input logic [63:0] p);
        return (p + ROUND_HALF) >> 16;
    endfunction

    // 0 reads as 1, anything above the limit reads as the limit
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v, input int hi);
        if (v == '0) begin
            return SIZE_W'(1);
        end
        if (32'(v) > hi) begin
            return SIZE_W'(hi);
        end
        return v;
    endfunction

endpackage

// ===== src/csmm_mul.sv =====
// Shared 32x32 unsigned multiplier with a registered product.
module csmm_mul import csmm_pkg::*; (
    input  logic        aclk,
    input  mul_req_t    req,
    output logic [63:0] prod
);

    logic [63:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= 64'(req.a) * 64'(req.b);
    end

    assign prod = prod_reg;

endmodule

// ===== src/csmm_seq.sv =====
// Sequencer, operand stores, accumulator and result register of the matrix multiplier.
module csmm_seq import csmm_pkg::*; #(
    parameter int MAX_ROWS     = DEF_MAX_ROWS,
    parameter int MAX_COLS     = DEF_MAX_COLS,
    parameter int MAX_INNER    = DEF_MAX_INNER,
    parameter int MAX_NONZEROS = DEF_MAX_NONZEROS
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  cfg_t    cfg,
    input  logic    in_valid,
    output logic    in_ready,
    input  item_t   in_item,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    localparam int RS_DEPTH = MAX_ROWS + 1;
    localparam int RS_AW    = $clog2(RS_DEPTH);
    localparam int NZ_AW    = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1;
    localparam int B_DEPTH  = MAX_INNER * MAX_COLS;
    localparam int B_AW     = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
    localparam int C_DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int C_AW     = (C_DEPTH > 1) ? $clog2(C_DEPTH) : 1;

    // stores
    logic [PTR_W-1:0] rs_mem  [RS_DEPTH];
    logic [VAL_W-1:0] nzv_mem [MAX_NONZEROS];
    logic [KC_W-1:0]  nzc_mem [MAX_NONZEROS];
    logic [VAL_W-1:0] b_mem   [B_DEPTH];
    logic [VAL_W-1:0] c_mem   [C_DEPTH];

    logic             rs_we, nz_we, b_we, c_we;
    logic [RS_AW-1:0] rs_wa, rs_ra;
    logic [NZ_AW-1:0] nz_wa, nz_ra;
    logic [B_AW-1:0]  b_wa, b_ra;
    logic [C_AW-1:0]  c_wa, c_ra;
    logic [VAL_W-1:0] c_wd;
    logic [PTR_W-1:0] rs_rd_reg;
    logic [VAL_W-1:0] nzv_rd_reg, b_rd_reg, c_rd_reg;
    logic [KC_W-1:0]  nzc_rd_reg;

    // sequencer state
    state_t            state_reg, state_next;
    logic [SIZE_W-1:0] i_reg, i_next, j_reg, j_next;
    logic [PTR_W-1:0]  e_reg, e_next, hi_reg, hi_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [VAL_W-1:0]  c_val_reg, c_val_next, a_val_reg, a_val_next;
    logic              sign_reg, sign_next;
    logic [63:0]       plo_reg, plo_next;
    logic [TOT_W-1:0]  t1_reg, t1_next, t2_reg, t2_next;
    logic [VAL_W-1:0]  res_val_reg, res_val_next;
    logic              res_sat_reg, res_sat_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_res_reg, out_res_next;

    mul_req_t    mul_req;
    logic [63:0] mul_prod;

    logic [ACC_W-1:0] acc_mag;
    logic [63:0]      term, amag, ar, bmag;
    logic [TOT_W-1:0] total;

    csmm_mul u_mul (
        .aclk (aclk),
        .req  (mul_req),
        .prod (mul_prod)
    );

    function automatic logic [C_AW-1:0] c_addr(input logic [SIZE_W-1:0] jj,
                                               input logic [SIZE_W-1:0] ii);
        return C_AW'(32'(jj) * MAX_ROWS + 32'(ii));
    endfunction

    function automatic logic [B_AW-1:0] b_addr(input logic [SIZE_W-1:0] jj,
                                               input logic [KC_W-1:0] kk);
        return B_AW'(32'(jj) * MAX_INNER + 32'(kk));
    endfunction

    always_ff @(posedge aclk) begin
        if (rs_we) begin
            rs_mem[rs_wa] <= in_item.pointer;
        end
        rs_rd_reg <= rs_mem[rs_ra];
    end

    always_ff @(posedge aclk) begin
        if (nz_we) begin
            nzv_mem[nz_wa] <= in_item.value;
            nzc_mem[nz_wa] <= in_item.column - 4'd1;
        end
        nzv_rd_reg <= nzv_mem[nz_ra];
        nzc_rd_reg <= nzc_mem[nz_ra];
    end

    always_ff @(posedge aclk) begin
        if (b_we) begin
            b_mem[b_wa] <= in_item.value;
        end
        b_rd_reg <= b_mem[b_ra];
    end

    always_ff @(posedge aclk) begin
        if (c_we) begin
            c_mem[c_wa] <= c_wd;
        end
        c_rd_reg <= c_mem[c_ra];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        i_reg       <= i_next;
        j_reg       <= j_next;
        e_reg       <= e_next;
        hi_reg      <= hi_next;
        acc_reg     <= acc_next;
        c_val_reg   <= c_val_next;
        a_val_reg   <= a_val_next;
        sign_reg    <= sign_next;
        plo_reg     <= plo_next;
        t1_reg      <= t1_next;
        t2_reg      <= t2_next;
        res_val_reg <= res_val_next;
        res_sat_reg <= res_sat_next;
        out_res_reg <= out_res_next;
    end

    assign rs_wa   = RS_AW'(in_item.slot);
    assign nz_wa   = NZ_AW'(in_item.slot);
    assign b_wa    = b_addr(SIZE_W'(in_item.col), KC_W'(in_item.row));
    assign acc_mag = acc_reg[ACC_W-1] ? (~acc_reg + ACC_W'(1)) : acc_reg;
    assign term    = rnd16(mul_prod);
    assign ar      = (mul_prod << 16) + rnd16(plo_reg);
    assign amag    = (mul_prod >= HI_LIMIT || ar > MAG_CAP) ? MAG_CAP : ar;
    assign bmag    = rnd16(mul_prod);
    assign total   = t1_reg + t2_reg;

    always_comb begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        e_next         = e_reg;
        hi_next        = hi_reg;
        acc_next       = acc_reg;
        c_val_next     = c_val_reg;
        a_val_next     = a_val_reg;
        sign_next      = sign_reg;
        plo_next       = plo_reg;
        t1_next        = t1_reg;
        t2_next        = t2_reg;
        res_val_next   = res_val_reg;
        res_sat_next   = res_sat_reg;
        out_res_next   = out_res_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        rs_we          = 1'b0;
        nz_we          = 1'b0;
        b_we           = 1'b0;
        c_we           = 1'b0;
        c_wa           = c_addr(SIZE_W'(in_item.col), SIZE_W'(in_item.row));
        c_wd           = in_item.value;
        rs_ra          = RS_AW'(i_reg);
        nz_ra          = NZ_AW'(e_reg - 7'd1);
        b_ra           = b_addr(j_reg, nzc_rd_reg);
        c_ra           = c_addr(j_reg, i_reg);
        mul_req        = '0;

        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    case (in_item.kind)
                        KIND_ROW_PTR: begin
                            rs_we = (32'(in_item.slot) <= MAX_ROWS);
                        end
                        KIND_NONZERO: begin
                            nz_we = (32'(in_item.slot) < MAX_NONZEROS);
                        end
                        KIND_B_ELEM: begin
                            b_we = (32'(in_item.row) < MAX_INNER) &&
                                   (32'(in_item.col) < MAX_COLS);
                        end
                        KIND_C_ELEM: begin
                            c_we = (32'(in_item.row) < MAX_ROWS) &&
                                   (32'(in_item.col) < MAX_COLS);
                        end
                        KIND_START: begin
                            i_next     = '0;
                            j_next     = '0;
                            state_next = ST_ROW_LO;
                        end
                        default: ;
                    endcase
                end
            end
            ST_ROW_LO: begin
                state_next = ST_ROW_HI;
            end
            ST_ROW_HI: begin
                rs_ra      = RS_AW'(i_reg + 4'd1);
                e_next     = rs_rd_reg;
                acc_next   = '0;
                state_next = ST_ROW_WAIT;
            end
            ST_ROW_WAIT: begin
                hi_next    = rs_rd_reg;
                c_val_next = c_rd_reg;
                state_next = ST_NZ_CHECK;
            end
            ST_NZ_CHECK: begin
                if (e_reg < hi_reg) begin
                    // pointer zero and pointers past the list carry no term
                    if (e_reg == '0 || 32'(e_reg) > MAX_NONZEROS) begin
                        e_next = e_reg + 7'd1;
                    end else begin
                        state_next = ST_NZ_READ;
                    end
                end else begin
                    state_next = ST_ALPHA_LO;
                end
            end
            ST_NZ_READ: begin
                a_val_next = nzv_rd_reg;
                if (nzc_rd_reg < cfg.inner) begin
                    state_next = ST_B_READ;
                end else begin
                    e_next     = e_reg + 7'd1;
                    state_next = ST_NZ_CHECK;
                end
            end
            ST_B_READ: begin
                mul_req.a  = mag32(a_val_reg);
                mul_req.b  = mag32(b_rd_reg);
                sign_next  = a_val_reg[31] ^ b_rd_reg[31];
                state_next = ST_MUL_WAIT;
            end
            ST_MUL_WAIT: begin
                acc_next   = sign_reg ? (acc_reg - ACC_W'(term)) : (acc_reg + ACC_W'(term));
                e_next     = e_reg + 7'd1;
                state_next = ST_NZ_CHECK;
            end
            ST_ALPHA_LO: begin
                mul_req.a  = mag32(cfg.alpha);
                mul_req.b  = acc_mag[31:0];
                state_next = ST_ALPHA_HI;
            end
            ST_ALPHA_HI: begin
                mul_req.a  = mag32(cfg.alpha);
                mul_req.b  = 32'(acc_mag[ACC_W-1:32]);
                plo_next   = mul_prod;
                state_next = ST_BETA;
            end
            ST_BETA: begin
                mul_req.a  = mag32(cfg.beta);
                mul_req.b  = mag32(c_val_reg);
                t1_next    = (cfg.alpha[31] ^ acc_reg[ACC_W-1]) ? TOT_W'(64'd0 - amag)
                                                                : TOT_W'(amag);
                state_next = ST_SUM;
            end
            ST_SUM: begin
                t2_next    = (cfg.beta[31] ^ c_val_reg[31]) ? TOT_W'(64'd0 - bmag)
                                                            : TOT_W'(bmag);
                state_next = ST_TOTAL;
            end
            ST_TOTAL: begin
                // fits in 32 bits when all bits from 31 up agree
                if (!total[TOT_W-1] && (|total[TOT_W-2:31])) begin
                    res_val_next = 32'h7FFF_FFFF;
                    res_sat_next = 1'b1;
                end else if (total[TOT_W-1] && !(&total[TOT_W-2:31])) begin
                    res_val_next = 32'h8000_0000;
                    res_sat_next = 1'b1;
                end else begin
                    res_val_next = total[31:0];
                    res_sat_next = 1'b0;
                end
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready) begin
                    out_valid_next         = 1'b1;
                    out_res_next.value     = res_val_reg;
                    out_res_next.row       = 3'(i_reg);
                    out_res_next.col       = 3'(j_reg);
                    out_res_next.saturated = res_sat_reg;
                    out_res_next.last      = (i_reg + 4'd1 == cfg.rows) &&
                                             (j_reg + 4'd1 == cfg.cols);
                    c_we                   = 1'b1;
                    c_wa                   = c_addr(j_reg, i_reg);
                    c_wd                   = res_val_reg;
                    if (i_reg + 4'd1 == cfg.rows) begin
                        i_next = '0;
                        if (j_reg + 4'd1 == cfg.cols) begin
                            state_next = ST_IDLE;
                        end else begin
                            j_next     = j_reg + 4'd1;
                            state_next = ST_ROW_LO;
                        end
                    end else begin
                        i_next     = i_reg + 4'd1;
                        state_next = ST_ROW_LO;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

// ===== src/csr_sparse_dense_matmul_top.sv =====
// Load items are accepted back to back, one per cycle while idle; they emit nothing.
// A start item computes C = alpha*A*B + beta*C through one shared 32x32 multiplier:
// for each C element it reads the row pointers, multiplies and accumulates each counted
// nonzero of the row (a bad column or a skipped pointer adds no term), applies alpha and
// beta, saturates and emits it, waiting out any output stall; the next item is accepted after the last C element.
// aresetn (synchronous, active low) clears the sequencer and output valid, restores sizes 8, alpha/beta 1.0.
module csr_sparse_dense_matmul_top import csmm_pkg::*; #(
    parameter int MAX_ROWS     = DEF_MAX_ROWS,
    parameter int MAX_COLS     = DEF_MAX_COLS,
    parameter int MAX_INNER    = DEF_MAX_INNER,
    parameter int MAX_NONZEROS = DEF_MAX_NONZEROS
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_data,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,  // slot[5:0], pointer[12:6], column[16:13], row[19:17],
                                  // col[22:20], value[54:23], zero pad[55]
    input  logic [2:0]  s_tuser,  // kind[2:0]
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // value_out[31:0], out_row[34:32], out_col[37:35],
                                  // zero pad[39:38]
    output logic        m_tuser,  // saturated
    output logic        m_tlast
);

    logic [SIZE_W-1:0] rows_reg, cols_reg, inner_reg;
    logic [VAL_W-1:0]  alpha_reg, beta_reg;
    cfg_t              cfg_eff;
    item_t             item;
    result_t           res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg  <= SIZE_W'(8);
            cols_reg  <= SIZE_W'(8);
            inner_reg <= SIZE_W'(8);
            alpha_reg <= 32'h0001_0000;
            beta_reg  <= 32'h0001_0000;
        end else if (cfg_valid) begin
            case (cfg_addr)
                CFG_ROWS:  rows_reg  <= cfg_data[SIZE_W-1:0];
                CFG_COLS:  cols_reg  <= cfg_data[SIZE_W-1:0];
                CFG_INNER: inner_reg <= cfg_data[SIZE_W-1:0];
                CFG_ALPHA: alpha_reg <= cfg_data;
                CFG_BETA:  beta_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_eff.rows  = clamp_size(rows_reg, MAX_ROWS);
        cfg_eff.cols  = clamp_size(cols_reg, MAX_COLS);
        cfg_eff.inner = clamp_size(inner_reg, MAX_INNER);
        cfg_eff.alpha = alpha_reg;
        cfg_eff.beta  = beta_reg;
    end

    always_comb begin
        item.kind    = s_tuser;
        item.slot    = s_tdata[5:0];
        item.pointer = s_tdata[12:6];
        item.column  = s_tdata[16:13];
        item.row     = s_tdata[19:17];
        item.col     = s_tdata[22:20];
        item.value   = s_tdata[54:23];
    end

    csmm_seq #(
        .MAX_ROWS     (MAX_ROWS),
        .MAX_COLS     (MAX_COLS),
        .MAX_INNER    (MAX_INNER),
        .MAX_NONZEROS (MAX_NONZEROS)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_eff),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {2'b00, res.col, res.row, res.value};
    assign m_tuser = res.saturated;
    assign m_tlast = res.last;

endmodule
